// ===== hdl/htss_pkg.sv =====
// ----------------------------------------------------------------------------
// htss_pkg - shared types and constants of the heating timer
// Transaction payloads, configuration bundle, command and state codes.
// ----------------------------------------------------------------------------
package htss_pkg;

  // Field widths
  localparam int unsigned ModeW    = 3;
  localparam int unsigned MinutesW = 10;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned CtrlW    = 2;
  localparam int unsigned PreheatW = 11;
  localparam int unsigned SecW     = 6;   // second within the current minute, 1..60
  localparam int unsigned DayW     = 11;  // minute of day
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  // Reset values and limits
  localparam logic [MinutesW-1:0] MaxMinutesRst  = 10'd240;
  localparam logic [PreheatW-1:0] PreheatRst     = 11'd5;
  localparam logic [MinutesW-1:0] DurationRst    = 10'd60;
  localparam logic [SecW-1:0]     SecPerMin      = 6'd60;
  localparam logic [DayW-1:0]     MinPerHour     = 11'd60;
  localparam logic [DayW:0]       MinPerDay      = 12'd1440;
  localparam logic [HourW-1:0]    LastHour       = 5'd23;
  localparam logic [MinuteW-1:0]  LastMinute     = 6'd59;

  // Command codes
  localparam logic [ModeW-1:0] ModeTick     = 3'd0;
  localparam logic [ModeW-1:0] ModeSetDur   = 3'd1;
  localparam logic [ModeW-1:0] ModeSetSched = 3'd2;
  localparam logic [ModeW-1:0] ModeCancel   = 3'd3;
  localparam logic [ModeW-1:0] ModeStart    = 3'd4;
  localparam logic [ModeW-1:0] ModeStop     = 3'd5;

  // Controller states as reported
  localparam logic [CtrlW-1:0] CtrlIdle    = 2'd0;
  localparam logic [CtrlW-1:0] CtrlSched   = 2'd1;
  localparam logic [CtrlW-1:0] CtrlRunning = 2'd2;
  localparam logic [CtrlW-1:0] CtrlTimeout = 2'd3;

  // Register indexes (paddr bit 2)
  localparam logic RegMaxMinutes = 1'b0;
  localparam logic RegPreheat    = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [MinutesW-1:0] duration_minutes;
    logic [HourW-1:0]    alarm_hour;
    logic [MinuteW-1:0]  alarm_minute;
    logic [HourW-1:0]    now_hour;
    logic [MinuteW-1:0]  now_minute;
    logic                heater_is_on;
  } in_t;

  typedef struct packed {
    logic [CtrlW-1:0]    ctrl_state;
    logic [MinutesW-1:0] remaining_minutes;
    logic                heater_off_cmd;
    logic                heater_on_cmd;
    logic                timeout_pulse;
    logic                schedule_stored;
    logic [HourW-1:0]    stored_hour;
    logic [MinuteW-1:0]  stored_minute;
  } out_t;

  typedef struct packed {
    logic [MinutesW-1:0] max_minutes;
    logic [PreheatW-1:0] preheat_minutes;
  } cfg_t;

endpackage

// ===== hdl/htss_cfg.sv =====
// ----------------------------------------------------------------------------
// htss_cfg - configuration registers
// APB-style register file holding the duration clamp and the preheat time.
// ----------------------------------------------------------------------------
module htss_cfg import htss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic                wr_en;
  logic [MinutesW-1:0] max_minutes_q;
  logic [PreheatW-1:0] preheat_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_minutes_q <= MaxMinutesRst;
      preheat_q     <= PreheatRst;
    end else if (wr_en) begin
      if (paddr[2] == RegMaxMinutes) begin
        max_minutes_q <= pwdata[MinutesW-1:0];
      end else begin
        preheat_q <= pwdata[PreheatW-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == RegMaxMinutes) begin
      prdata = PdataW'(max_minutes_q);
    end else begin
      prdata = PdataW'(preheat_q);
    end
  end

  assign cfg_o.max_minutes     = max_minutes_q;
  assign cfg_o.preheat_minutes = preheat_q;

endmodule

// ===== hdl/htss_core.sv =====
// ----------------------------------------------------------------------------
// htss_core - timer and schedule state with its single-pass update
// Applies one command or tick per step and forms the result transaction.
// ----------------------------------------------------------------------------
module htss_core import htss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  // Countdown kept as whole minutes (rounded up) plus second within minute
  logic [MinutesW-1:0] duration_q, duration_d;
  logic [MinutesW-1:0] mins_q, mins_d;
  logic [SecW-1:0]     sub_q, sub_d;
  logic                counting_q, counting_d;
  logic                armed_q, armed_d;
  logic                present_q, present_d;
  logic [HourW-1:0]    hour_q, hour_d;
  logic [MinuteW-1:0]  minute_q, minute_d;
  logic [CtrlW-1:0]    state_q, state_d;

  logic                heater;
  logic                off_cmd;
  logic                on_cmd;
  logic [MinutesW-1:0] dur_lo;
  logic [MinutesW-1:0] dur_clamped;
  logic [DayW-1:0]     sched_day;
  logic [DayW-1:0]     now_day;
  logic signed [DayW:0] start_raw;
  logic signed [DayW:0] start_adj;
  logic                start_hit;

  // Trigger time: scheduled minute of day less preheat, wrapped once
  always_comb begin
    sched_day = DayW'(hour_q) * MinPerHour + DayW'(minute_q);
    now_day   = DayW'(item_i.now_hour) * MinPerHour + DayW'(item_i.now_minute);
    start_raw = $signed({1'b0, sched_day}) - $signed({1'b0, cfg_i.preheat_minutes});
    if (start_raw[DayW]) begin
      start_adj = start_raw + $signed(MinPerDay);
    end else begin
      start_adj = start_raw;
    end
    start_hit = !start_adj[DayW] && (start_adj[DayW-1:0] == now_day);
  end

  // Duration clamp: raise to one, then lower to the maximum
  always_comb begin
    dur_lo      = (item_i.duration_minutes == '0) ? MinutesW'(1) : item_i.duration_minutes;
    dur_clamped = (dur_lo > cfg_i.max_minutes) ? cfg_i.max_minutes : dur_lo;
  end

  // Next state
  always_comb begin
    duration_d = duration_q;
    mins_d     = mins_q;
    sub_d      = sub_q;
    counting_d = counting_q;
    armed_d    = armed_q;
    present_d  = present_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    state_d    = state_q;
    heater     = item_i.heater_is_on;
    off_cmd    = 1'b0;
    on_cmd     = 1'b0;

    case (item_i.mode)
      ModeTick: begin
        if (counting_q && heater) begin
          if ((mins_q == '0) || ((mins_q == MinutesW'(1)) && (sub_q == SecW'(1)))) begin
            counting_d = 1'b0;
            mins_d     = '0;
            sub_d      = '0;
            state_d    = CtrlTimeout;
            heater     = 1'b0;
            off_cmd    = 1'b1;
          end else if (sub_q > SecW'(1)) begin
            sub_d = sub_q - SecW'(1);
          end else begin
            mins_d = mins_q - MinutesW'(1);
            sub_d  = SecPerMin;
          end
        end
        if (armed_q && !heater && start_hit) begin
          on_cmd     = 1'b1;
          armed_d    = 1'b0;
          counting_d = 1'b1;
          mins_d     = duration_q;
          sub_d      = SecPerMin;
          state_d    = CtrlRunning;
        end
      end
      ModeSetDur: begin
        duration_d = dur_clamped;
        if (heater) begin
          counting_d = 1'b1;
          mins_d     = dur_clamped;
          sub_d      = SecPerMin;
          state_d    = CtrlRunning;
        end
      end
      ModeSetSched: begin
        if ((item_i.alarm_hour <= LastHour) && (item_i.alarm_minute <= LastMinute)) begin
          hour_d    = item_i.alarm_hour;
          minute_d  = item_i.alarm_minute;
          present_d = 1'b1;
          armed_d   = 1'b1;
          state_d   = CtrlSched;
        end
      end
      ModeCancel: begin
        armed_d   = 1'b0;
        present_d = 1'b0;
        hour_d    = '0;
        minute_d  = '0;
        if (state_q == CtrlSched) begin
          state_d = CtrlIdle;
        end
      end
      ModeStart: begin
        counting_d = 1'b1;
        mins_d     = duration_q;
        sub_d      = SecPerMin;
        state_d    = CtrlRunning;
      end
      ModeStop: begin
        counting_d = 1'b0;
        mins_d     = '0;
        sub_d      = '0;
        if ((state_q == CtrlRunning) || (state_q == CtrlTimeout)) begin
          state_d = CtrlIdle;
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= DurationRst;
      mins_q     <= '0;
      sub_q      <= '0;
      counting_q <= 1'b0;
      armed_q    <= 1'b0;
      present_q  <= 1'b0;
      hour_q     <= '0;
      minute_q   <= '0;
      state_q    <= CtrlIdle;
    end else if (step_i) begin
      duration_q <= duration_d;
      mins_q     <= mins_d;
      sub_q      <= sub_d;
      counting_q <= counting_d;
      armed_q    <= armed_d;
      present_q  <= present_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      state_q    <= state_d;
    end
  end

  // Result of this step
  always_comb begin
    result_o.ctrl_state        = state_d;
    result_o.remaining_minutes = mins_d;
    result_o.heater_off_cmd    = off_cmd;
    result_o.heater_on_cmd     = on_cmd;
    result_o.timeout_pulse     = off_cmd;
    result_o.schedule_stored   = present_d;
    result_o.stored_hour       = present_d ? hour_d : '0;
    result_o.stored_minute     = present_d ? minute_d : '0;
  end

`ifndef SYNTHESIS
  // Second-within-minute is in range while minutes remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mins_q != '0) |-> ((sub_q >= SecW'(1)) && (sub_q <= SecPerMin)))
    else $error("htss_core: second counter out of range");

  // A stopped countdown holds no minutes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !counting_q |-> (mins_q == '0))
    else $error("htss_core: minutes left while not counting");

  // Armed implies a stored schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> present_q)
    else $error("htss_core: schedule armed without stored time");

  // No stored time reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !present_q |-> ((hour_q == '0) && (minute_q == '0)))
    else $error("htss_core: stale schedule time");

  // A schedule trigger starts the countdown and disarms
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && on_cmd) |=> (counting_q && !armed_q && (state_q == CtrlRunning)))
    else $error("htss_core: trigger did not start countdown");
`endif

endmodule

// ===== hdl/heating_timer_with_scheduled_start.sv =====
// ----------------------------------------------------------------------------
// heating_timer_with_scheduled_start - appliance auto-off timer
// Top level: input register, timer core, result register, APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one tick or
//   command per transaction; output channel (out_valid_o/out_ready_i/
//   out_data_o) returns exactly one result transaction for each input.
//   The APB port sets the duration clamp and the preheat time; write it only
//   while no transaction is in flight.
// Path: an accepted input transaction is held in the input register; its
//   result is then captured in the result register and offered on the
//   output channel until it is taken.
// Throughput: one transaction per cycle while out_ready_i is high; the core
//   updates its state in a single pass, so back-to-back ticks and commands are accepted.
// Reset: asynchronous, active low; the timer is idle, no schedule is stored,
//   duration 60 minutes, clamp 240, preheat 5. Both pipeline slots empty.
// Stall: while out_ready_i is low the result is held and the input register
//   still takes one more transaction if it is empty; after that in_ready_o
//   drops.
// ----------------------------------------------------------------------------
module heating_timer_with_scheduled_start import htss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic in_valid_q;
  in_t  in_item_q;
  logic out_valid_q;
  out_t out_data_q;
  out_t result;
  logic out_free;
  logic step;

  htss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake between the two slots
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  htss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== test/heating_timer_with_scheduled_start_test.sv =====
// ----------------------------------------------------------------------------
// heating_timer_with_scheduled_start_test - self-checking bench of the timer
// A short table of directed transactions (idle state, clamps, invalid
// schedules, trigger across midnight, expiry and trigger in one tick, large
// preheat) is followed by random phases under several register settings.
// Every result is compared field by field, with the table's expected value
// where a row gives one, else with a cycle-free model of the timer that the bench keeps.
// ----------------------------------------------------------------------------
module heating_timer_with_scheduled_start_test;
  import htss_pkg::*;

  // Modes with no function in the block
  localparam logic [ModeW-1:0] ModeSpareA = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareB = 3'd7;

  localparam int PipeDepth   = 2;
  localparam int StallLimit  = 2000;  // cycles without any transaction
  localparam int HoldCycles  = 120;   // long receiver hold-off
  localparam int Phases      = 6;
  localparam int PhaseItems  = 205;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic                reg_sel;
    logic [PdataW-1:0]   wdata;
    in_t                 item;
    bit                  typed;
    out_t                want;
  } plan_row_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  // Block ports
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_t              out_data_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [PdataW-1:0] pwdata  = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  heating_timer_with_scheduled_start dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Timer model state, reset values
  logic [MinutesW-1:0] lim_min     = MaxMinutesRst;
  logic [PreheatW-1:0] lead_min    = PreheatRst;
  logic [MinutesW-1:0] run_len_min = DurationRst;
  logic [15:0]         secs_to_go  = '0;
  logic [MinutesW-1:0] mins_to_go  = '0;
  bit                  cd_active   = 1'b0;
  bit                  sch_armed   = 1'b0;
  bit                  sch_held    = 1'b0;
  logic [HourW-1:0]    sch_hour    = '0;
  logic [MinuteW-1:0]  sch_min     = '0;
  logic [CtrlW-1:0]    ctl         = CtrlIdle;

  // Bench bookkeeping
  out_t      pending_status[$];
  plan_row_t plan[$];
  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        tx_gap_pct   = 0;
  int        rx_stall_pct = 0;
  int        tick_run     = 0;
  bit        quiet        = 1'b0;
  bit        hold_off     = 1'b0;
  bit        heater_now   = 1'b0;

  // Minute of day at which the schedule fires; negative means never
  function automatic int sched_start_minute();
    int m;
    m = int'(sch_hour) * int'(MinPerHour) + int'(sch_min) - int'(lead_min);
    if (m < 0) m += int'(MinPerDay);
    return m;
  endfunction

  task automatic start_countdown();
    cd_active  = 1'b1;
    secs_to_go = 16'(int'(run_len_min) * int'(SecPerMin));
    mins_to_go = run_len_min;
    ctl        = CtrlRunning;
  endtask

  // One transaction through the timer model
  task automatic advance_timer(input in_t it, output out_t res);
    logic [MinutesW-1:0] req;
    bit                  heat;
    bit                  off_now;
    bit                  on_now;
    heat    = it.heater_is_on;
    off_now = 1'b0;
    on_now  = 1'b0;
    case (it.mode)
      ModeTick: begin
        if (cd_active && heat) begin
          if (secs_to_go <= 16'd1) begin
            cd_active  = 1'b0;
            secs_to_go = '0;
            mins_to_go = '0;
            ctl        = CtrlTimeout;
            heat       = 1'b0;
            off_now    = 1'b1;
          end else begin
            secs_to_go = secs_to_go - 16'd1;
            mins_to_go = MinutesW'((int'(secs_to_go) + int'(SecPerMin) - 1)
                                   / int'(SecPerMin));
          end
        end
        // schedule check sees the heater as left by the countdown above
        if (sch_armed && !heat && sched_start_minute() >= 0 &&
            int'(it.now_hour) * int'(MinPerHour) + int'(it.now_minute)
              == sched_start_minute()) begin
          on_now    = 1'b1;
          sch_armed = 1'b0;
          start_countdown();
        end
      end
      ModeSetDur: begin
        req = it.duration_minutes;
        if (req == '0) req = 10'd1;
        if (req > lim_min) req = lim_min;
        run_len_min = req;
        if (heat) start_countdown();
      end
      ModeSetSched: begin
        if (it.alarm_hour <= LastHour && it.alarm_minute <= LastMinute) begin
          sch_hour  = it.alarm_hour;
          sch_min   = it.alarm_minute;
          sch_held  = 1'b1;
          sch_armed = 1'b1;
          ctl       = CtrlSched;
        end
      end
      ModeCancel: begin
        sch_armed = 1'b0;
        sch_held  = 1'b0;
        sch_hour  = '0;
        sch_min   = '0;
        if (ctl == CtrlSched) ctl = CtrlIdle;
      end
      ModeStart: start_countdown();
      ModeStop: begin
        cd_active  = 1'b0;
        secs_to_go = '0;
        mins_to_go = '0;
        if (ctl == CtrlRunning || ctl == CtrlTimeout) ctl = CtrlIdle;
      end
      default: ;
    endcase
    res.ctrl_state        = ctl;
    res.remaining_minutes = mins_to_go;
    res.heater_off_cmd    = off_now;
    res.heater_on_cmd     = on_now;
    res.timeout_pulse     = off_now;
    res.schedule_stored   = sch_held;
    res.stored_hour       = sch_held ? sch_hour : '0;
    res.stored_minute     = sch_held ? sch_min : '0;
  endtask

  // Table helpers
  function automatic in_t cmd_item(logic [ModeW-1:0] mode, int dur, int sh, int sm,
                                   int nh, int nm, bit heat);
    in_t it;
    it.mode             = mode;
    it.duration_minutes = MinutesW'(dur);
    it.alarm_hour       = HourW'(sh);
    it.alarm_minute     = MinuteW'(sm);
    it.now_hour         = HourW'(nh);
    it.now_minute       = MinuteW'(nm);
    it.heater_is_on     = heat;
    return it;
  endfunction

  function automatic out_t status(logic [CtrlW-1:0] cs, int rem, bit off, bit on,
                                  bit stored, int hr, int mn);
    out_t r;
    r.ctrl_state        = cs;
    r.remaining_minutes = MinutesW'(rem);
    r.heater_off_cmd    = off;
    r.heater_on_cmd     = on;
    r.timeout_pulse     = off;
    r.schedule_stored   = stored;
    r.stored_hour       = HourW'(hr);
    r.stored_minute     = MinuteW'(mn);
    return r;
  endfunction

  function automatic plan_row_t item_row(in_t it);
    plan_row_t r;
    r.kind    = RowItem;
    r.reg_sel = 1'b0;
    r.wdata   = '0;
    r.item    = it;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t checked_row(in_t it, out_t want);
    plan_row_t r;
    r       = item_row(it);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic sel, int val);
    plan_row_t r;
    r         = item_row('0);
    r.kind    = RowReg;
    r.reg_sel = sel;
    r.wdata   = PdataW'(val);
    return r;
  endfunction

  // Offer one transaction, hold it until accepted, then log its prediction
  task automatic push_item(input in_t it, input bit typed, input out_t want);
    out_t guess;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(negedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    advance_timer(it, guess);
    pending_status.push_back(typed ? want : guess);
    if (guess.heater_off_cmd) heater_now = 1'b0;
    if (guess.heater_on_cmd) heater_now = 1'b1;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then idle with psel low
  task automatic write_reg(input logic sel, input logic [PdataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({sel, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == RegMaxMinutes) lim_min = val[MinutesW-1:0];
    else lead_min = val[PreheatW-1:0];
    @(posedge clk_i);
  endtask

  // Random transaction: mostly runs of ticks with the clock near the
  // scheduled start, commands in between, some out-of-range noise
  task automatic gen_item(output in_t it);
    int pick;
    int m;
    pick = $urandom_range(0, 99);
    if (tick_run > 0) begin
      tick_run--;
      it.mode = ModeTick;
    end else if (pick < 55) begin
      it.mode = ModeTick;
      if ($urandom_range(0, 3) == 0) tick_run = $urandom_range(30, 130);
    end else if (pick < 67) it.mode = ModeSetDur;
    else if (pick < 79) it.mode = ModeSetSched;
    else if (pick < 84) it.mode = ModeCancel;
    else if (pick < 91) it.mode = ModeStart;
    else if (pick < 97) it.mode = ModeStop;
    else it.mode = pick[0] ? ModeSpareA : ModeSpareB;

    it.duration_minutes = ($urandom_range(0, 3) == 0) ? MinutesW'($urandom)
                                                      : MinutesW'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) begin
      it.alarm_hour   = HourW'($urandom);
      it.alarm_minute = MinuteW'($urandom);
    end else begin
      it.alarm_hour   = HourW'($urandom_range(0, int'(LastHour)));
      it.alarm_minute = MinuteW'($urandom_range(0, int'(LastMinute)));
    end

    m = sched_start_minute();
    if (sch_armed && m >= 0 && $urandom_range(0, 1) == 1) begin
      m = (m + int'(MinPerDay) + int'($urandom_range(0, 2)) - 1) % int'(MinPerDay);
      it.now_hour   = HourW'(m / int'(MinPerHour));
      it.now_minute = MinuteW'(m % int'(MinPerHour));
    end else if ($urandom_range(0, 19) == 0) begin
      it.now_hour   = HourW'($urandom);
      it.now_minute = MinuteW'($urandom);
    end else begin
      it.now_hour   = HourW'($urandom_range(0, int'(LastHour)));
      it.now_minute = MinuteW'($urandom_range(0, int'(LastMinute)));
    end

    // user fiddling with the heater now and then
    if ($urandom_range(0, 29) == 0) heater_now = !heater_now;
    if (it.mode == ModeStart && $urandom_range(0, 3) != 0) heater_now = 1'b1;
    it.heater_is_on = ($urandom_range(0, 9) == 0) ? 1'($urandom) : heater_now;
  endtask

  task automatic note_field(input string name, input int unsigned want,
                            input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  // Result checker and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin : result_check
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %h",
                   $time, out_data_o);
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          if (out_data_o.ctrl_state !== want.ctrl_state)
            note_field("ctrl_state", want.ctrl_state, out_data_o.ctrl_state);
          if (out_data_o.remaining_minutes !== want.remaining_minutes)
            note_field("remaining_minutes", want.remaining_minutes,
                       out_data_o.remaining_minutes);
          if (out_data_o.heater_off_cmd !== want.heater_off_cmd)
            note_field("heater_off_cmd", want.heater_off_cmd, out_data_o.heater_off_cmd);
          if (out_data_o.heater_on_cmd !== want.heater_on_cmd)
            note_field("heater_on_cmd", want.heater_on_cmd, out_data_o.heater_on_cmd);
          if (out_data_o.timeout_pulse !== want.timeout_pulse)
            note_field("timeout_pulse", want.timeout_pulse, out_data_o.timeout_pulse);
          if (out_data_o.schedule_stored !== want.schedule_stored)
            note_field("schedule_stored", want.schedule_stored,
                       out_data_o.schedule_stored);
          if (out_data_o.stored_hour !== want.stored_hour)
            note_field("stored_hour", want.stored_hour, out_data_o.stored_hour);
          if (out_data_o.stored_minute !== want.stored_minute)
            note_field("stored_minute", want.stored_minute, out_data_o.stored_minute);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    in_t it;
    // directed table, reset settings first (clamp 240, preheat 5)
    plan.push_back(checked_row(cmd_item(ModeTick, 0, 0, 0, 0, 0, 0),
                               status(CtrlIdle, 0, 0, 0, 0, 0, 0)));
    plan.push_back(checked_row(cmd_item(ModeSpareA, 1023, 31, 63, 31, 63, 1),
                               status(CtrlIdle, 0, 0, 0, 0, 0, 0)));
    plan.push_back(checked_row(cmd_item(ModeSpareB, 0, 0, 0, 0, 0, 0),
                               status(CtrlIdle, 0, 0, 0, 0, 0, 0)));
    // duration raised to 1, heater off so nothing starts
    plan.push_back(checked_row(cmd_item(ModeSetDur, 0, 0, 0, 0, 0, 0),
                               status(CtrlIdle, 0, 0, 0, 0, 0, 0)));
    // clamped to 240 and restarted since the heater is on
    plan.push_back(checked_row(cmd_item(ModeSetDur, 1023, 0, 0, 0, 0, 1),
                               status(CtrlRunning, 240, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 0, 0, 1)));
    plan.push_back(checked_row(cmd_item(ModeStop, 0, 0, 0, 0, 0, 1),
                               status(CtrlIdle, 0, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeStart, 0, 0, 0, 0, 0, 0)));
    // invalid schedules are dropped
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 24, 0, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 23, 63, 0, 0, 0)));
    // 00:02 less 5 minutes preheat wraps to 23:57
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 0, 2, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 23, 57, 0)));
    plan.push_back(item_row(cmd_item(ModeCancel, 0, 0, 0, 0, 0, 1)));
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 23, 59, 0, 0, 0)));
    // clock out of range never matches
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 31, 63, 0)));
    plan.push_back(item_row(cmd_item(ModeStop, 0, 0, 0, 0, 0, 0)));
    // zero clamp, no preheat: expiry and trigger in the same tick
    plan.push_back(reg_row(RegMaxMinutes, 0));
    plan.push_back(reg_row(RegPreheat, 0));
    plan.push_back(item_row(cmd_item(ModeSetDur, 0, 0, 0, 0, 0, 1)));
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 12, 34, 0, 0, 1)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 12, 34, 1)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 12, 35, 1)));
    plan.push_back(item_row(cmd_item(ModeStop, 0, 0, 0, 0, 0, 0)));
    // widest clamp, preheat of almost a day
    plan.push_back(reg_row(RegMaxMinutes, 1023));
    plan.push_back(reg_row(RegPreheat, 1439));
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 0, 1, 0)));
    plan.push_back(checked_row(cmd_item(ModeSetDur, 1023, 0, 0, 0, 0, 1),
                               status(CtrlRunning, 1023, 0, 0, 1, 0, 0)));
    // preheat beyond a day: the schedule can never fire
    plan.push_back(reg_row(RegPreheat, 2047));
    plan.push_back(item_row(cmd_item(ModeSetSched, 0, 0, 0, 0, 0, 0)));
    plan.push_back(item_row(cmd_item(ModeTick, 0, 0, 0, 0, 0, 0)));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowReg) begin
        drain_results();
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < Phases; p++) begin
      drain_results();
      case (p)
        0: begin
          write_reg(RegMaxMinutes, PdataW'(MaxMinutesRst));
          write_reg(RegPreheat, PdataW'(PreheatRst));
          tx_gap_pct   = 20;
          rx_stall_pct = 20;
        end
        1: begin
          write_reg(RegMaxMinutes, 1);
          write_reg(RegPreheat, 0);
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        2: begin
          write_reg(RegMaxMinutes, 1023);
          write_reg(RegPreheat, 1439);
          tx_gap_pct   = 40;
          rx_stall_pct = 40;
        end
        3: begin
          write_reg(RegMaxMinutes, 0);
          write_reg(RegPreheat, 2047);
          tx_gap_pct   = 10;
          rx_stall_pct = 30;
        end
        4: begin
          write_reg(RegMaxMinutes, 3);
          write_reg(RegPreheat, $urandom_range(0, 1439));
          tx_gap_pct   = 30;
          rx_stall_pct = 10;
        end
        default: begin
          write_reg(RegMaxMinutes, $urandom_range(1, 1023));
          write_reg(RegPreheat, $urandom_range(0, 1439));
          quiet = 1'b1;
        end
      endcase
      tick_run = 0;
      for (int k = 0; k < PhaseItems; k++) begin
        // fill the pipeline against a stalled receiver
        if (p == 0 && k == 40) hold_off = 1'b1;
        // sender pause until the block has drained
        if (p == 2 && k == 100) drain_results();
        gen_item(it);
        push_item(it, 1'b0, '0);
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
        end
      end
    end

    drain_results();
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/htss_pkg.sv
hdl/htss_cfg.sv
hdl/htss_core.sv
hdl/heating_timer_with_scheduled_start.sv
test/heating_timer_with_scheduled_start_test.sv
